FILE: rtl/esp3_pkg.sv
// ----------------------------------------------------------------------------
// esp3_pkg
// Shared constants and the CRC-8 step function of the serial packet deframer.
// ----------------------------------------------------------------------------
package esp3_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 64;
    localparam int HEADER_BYTES        = 6;
    localparam logic [7:0] SYNC_VALUE  = 8'h55;
    localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd1000;

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    // One CRC-8 step, polynomial 0x07, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        c = crc ^ d;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: rtl/esp3_if.sv
// ----------------------------------------------------------------------------
// esp3_in_if / esp3_out_if / esp3_cfg_if
// Valid/ready channels of the deframer.
// ----------------------------------------------------------------------------
interface esp3_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] rx_byte;
    modport source (output valid, mode, rx_byte, input ready);
    modport sink (input valid, mode, rx_byte, output ready);
endinterface

interface esp3_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic [5:0] byte_index;
    logic [5:0] data_length;
    logic [5:0] optional_length;
    logic       last;
    modport source (output valid, packet_byte, byte_index, data_length,
                    optional_length, last, input ready);
    modport sink (input valid, packet_byte, byte_index, data_length,
                  optional_length, last, output ready);
endinterface

interface esp3_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: rtl/esp3_packet_deframer.sv
// ----------------------------------------------------------------------------
// esp3_packet_deframer
// Collects serial bytes in a buffer memory, finds sync-led frames, checks
// both CRC-8 values and emits good frames one byte per output word.
// ----------------------------------------------------------------------------
//  channel   dir  contents
//  in_ch     in   mode, rx_byte
//  out_ch    out  packet_byte, byte_index, data_length, optional_length, last
//  cfg_ch    in   gap_timeout_ticks
//
// A tick, flush or unused-mode word is handled in the idle state. A
// received byte is written into a circular buffer memory (one read port,
// registered data) in its accept cycle. The frame search then walks that
// memory through the single read port: the sync hunt reads each leading
// byte and tests it before the next read, while the header, the data,
// optional and CRC bytes, the positions scanned in a resync and the output
// words are read in turn with each read issued as the last one returns.
// The buffer is a ring with a head pointer, so dropping leading bytes only
// moves the pointer. Reset clears the state, pointers and counters and
// loads the default gap timeout only; no memory clearing pass is needed.
// Output words stall the emit pass while out_ch is not ready; one input
// word is taken only when the engine is idle.
// ----------------------------------------------------------------------------
module esp3_packet_deframer #(
    parameter int MAX_FRAME_BYTES = esp3_pkg::MAX_FRAME_BYTES_DEF
) (
    input logic       clk,
    input logic       rst_n,
    esp3_in_if.sink   in_ch,
    esp3_out_if.source out_ch,
    esp3_cfg_if.sink  cfg_ch
);
    import esp3_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] DEPTH = CW'(MAX_FRAME_BYTES);

    // Engine states.
    localparam logic [2:0] S_IDLE = 3'd0;   // waiting for an input word
    localparam logic [2:0] S_HUNT = 3'd1;   // skip leading non-sync bytes
    localparam logic [2:0] S_HDR  = 3'd2;   // read header bytes 1..5
    localparam logic [2:0] S_DATA = 3'd3;   // CRC over data and optional bytes
    localparam logic [2:0] S_RSYN = 3'd4;   // look for the next sync
    localparam logic [2:0] S_EMIT = 3'd5;   // stream the frame out

    // The ring spans the full pointer range so that wrapping stays correct
    // for any buffer size.
    logic [7:0]    mem [2**AW];
    logic [7:0]    rd_data;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [15:0]   idle_reg, idle_next;
    logic [15:0]   gap_reg;
    // Position within the frame of the byte being fetched / returned.
    logic [CW-1:0] pos_reg, pos_next;
    logic          pend_reg, pend_next;   // read data is waiting in rd_data
    logic [CW-1:0] ppos_reg;              // position of the returned byte
    logic [7:0]    crc_reg, crc_next;
    logic [15:0]   dlen_reg, dlen_next;
    logic [7:0]    olen_reg, olen_next;
    logic [CW-1:0] total_reg, total_next;

    logic          ov_reg;
    logic [7:0]    ov_byte_reg;
    logic [5:0]    ov_idx_reg, ov_dl_reg, ov_ol_reg;
    logic          ov_last_reg;
    logic          ov_load;

    logic          in_fire;
    logic [CW-1:0] fill_app;   // fill before the append
    logic [10:0]   total_w;

    assign in_fire   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;

    assign out_ch.valid           = ov_reg;
    assign out_ch.packet_byte     = ov_byte_reg;
    assign out_ch.byte_index      = ov_idx_reg;
    assign out_ch.data_length     = ov_dl_reg;
    assign out_ch.optional_length = ov_ol_reg;
    assign out_ch.last            = ov_last_reg;

    always_comb
    begin
        fill_app = fill_reg;
        if (fill_reg != '0 && idle_reg > gap_reg)
        begin
            fill_app = '0;
        end
        if (fill_app >= DEPTH)
        begin
            fill_app = '0;
        end
    end

    // Frame length from the header, including the data CRC.
    assign total_w = 11'(HEADER_BYTES + 1) + 11'(dlen_reg[9:0]) + 11'(olen_reg);

    assign wr_en   = in_fire && in_ch.mode == MODE_BYTE;
    assign wr_addr = AW'(head_reg + AW'(fill_app));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_ch.rx_byte;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        idle_next  = idle_reg;
        pos_next   = pos_reg;
        pend_next  = 1'b0;
        crc_next   = crc_reg;
        dlen_next  = dlen_reg;
        olen_next  = olen_reg;
        total_next = total_reg;
        rd_en      = 1'b0;
        rd_addr    = AW'(head_reg + AW'(pos_reg));
        ov_load    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_ch.mode)
                        MODE_TICK:
                        begin
                            if (idle_reg != 16'hFFFF)
                            begin
                                idle_next = idle_reg + 16'd1;
                            end
                        end
                        MODE_FLUSH:
                        begin
                            fill_next = '0;
                        end
                        MODE_BYTE:
                        begin
                            idle_next  = '0;
                            fill_next  = fill_app + CW'(1);
                            pos_next   = '0;
                            state_next = S_HUNT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_HUNT:
            begin
                // Read position 0; drop it while it is not the sync value.
                if (fill_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (!pend_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = head_reg;
                    pend_next = 1'b1;
                end
                else if (rd_data != SYNC_VALUE)
                begin
                    head_next = AW'(head_reg + AW'(1));
                    fill_next = fill_reg - CW'(1);
                end
                else if (fill_reg < CW'(HEADER_BYTES))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    pos_next   = CW'(1);
                    crc_next   = '0;
                    state_next = S_HDR;
                end
            end
            S_HDR:
            begin
                if (pend_reg)
                begin
                    case (ppos_reg)
                        CW'(1): dlen_next[15:8] = rd_data;
                        CW'(2): dlen_next[7:0]  = rd_data;
                        CW'(3): olen_next       = rd_data;
                        default:
                        begin
                        end
                    endcase
                    if (ppos_reg != CW'(5))
                    begin
                        crc_next = crc8_byte(crc_reg, rd_data);
                    end
                end
                if (pend_reg && ppos_reg == CW'(5))
                begin
                    if (dlen_reg > 16'(MAX_FRAME_BYTES) ||
                        total_w > 11'(MAX_FRAME_BYTES))
                    begin
                        pos_next   = CW'(1);
                        state_next = S_RSYN;
                    end
                    else if (fill_reg < CW'(total_w))
                    begin
                        state_next = S_IDLE;
                    end
                    else if (rd_data != crc_reg)
                    begin
                        pos_next   = CW'(1);
                        state_next = S_RSYN;
                    end
                    else
                    begin
                        total_next = CW'(total_w);
                        crc_next   = '0;
                        pos_next   = CW'(HEADER_BYTES);
                        state_next = S_DATA;
                    end
                end
                else if (pos_reg <= CW'(5))
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    pos_next  = pos_reg + CW'(1);
                end
            end
            S_DATA:
            begin
                if (pend_reg && ppos_reg == total_reg - CW'(1))
                begin
                    if (rd_data != crc_reg)
                    begin
                        pos_next   = CW'(1);
                        state_next = S_RSYN;
                    end
                    else
                    begin
                        pos_next   = '0;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    if (pend_reg)
                    begin
                        crc_next = crc8_byte(crc_reg, rd_data);
                    end
                    if (pos_reg < total_reg)
                    begin
                        rd_en     = 1'b1;
                        pend_next = 1'b1;
                        pos_next  = pos_reg + CW'(1);
                    end
                end
            end
            S_RSYN:
            begin
                if (pend_reg && rd_data == SYNC_VALUE)
                begin
                    head_next  = AW'(head_reg + AW'(ppos_reg));
                    fill_next  = fill_reg - ppos_reg;
                    pos_next   = '0;
                    state_next = S_HUNT;
                end
                else if (pos_reg >= fill_reg)
                begin
                    if (!pend_reg)
                    begin
                        fill_next  = '0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    pos_next  = pos_reg + CW'(1);
                end
            end
            S_EMIT:
            begin
                // One read in flight; the word goes out when the register frees.
                if (pend_reg)
                begin
                    if (!ov_reg || out_ch.ready)
                    begin
                        ov_load = 1'b1;
                        if (ppos_reg == total_reg - CW'(1))
                        begin
                            head_next  = AW'(head_reg + AW'(total_reg));
                            fill_next  = fill_reg - total_reg;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            rd_en     = 1'b1;
                            pend_next = 1'b1;
                            pos_next  = pos_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        pend_next = 1'b1;
                    end
                end
                else
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    pos_next  = pos_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            idle_reg  <= '0;
            gap_reg   <= GAP_TIMEOUT_RESET;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            idle_reg  <= idle_next;
            pend_reg  <= pend_next;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                gap_reg <= cfg_ch.data;
            end
            if (ov_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        crc_reg   <= crc_next;
        dlen_reg  <= dlen_next;
        olen_reg  <= olen_next;
        total_reg <= total_next;
        if (rd_en)
        begin
            ppos_reg <= pos_reg;
        end
        if (ov_load)
        begin
            ov_byte_reg <= rd_data;
            ov_idx_reg  <= ppos_reg[5:0];
            ov_dl_reg   <= dlen_reg[5:0];
            ov_ol_reg   <= olen_reg[5:0];
            ov_last_reg <= (ppos_reg == total_reg - CW'(1));
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH)
        else $error("buffer fill above depth");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !pend_reg)
        else $error("read in flight while idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ch.ready) |=> ov_reg)
        else $error("output word lost");
    a_emit_first: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_load && ppos_reg == '0) |-> rd_data == SYNC_VALUE)
        else $error("frame does not start with sync");
`endif

endmodule

FILE: test/esp3_deframer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// esp3_deframer_checker
// Watches the input, output and configuration channels of the deframer,
// predicts every output word from the accepted input words and compares
// them field by field in order.
// ----------------------------------------------------------------------------
module esp3_deframer_checker
    import esp3_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    esp3_in_if.sink       in_mon,
    esp3_out_if.sink      out_mon,
    esp3_cfg_if.sink      cfg_mon,
    output int            fail_count,
    output int            pending_words
);

    typedef struct packed {
        logic [7:0] packet_byte;
        logic [5:0] byte_index;
        logic [5:0] data_length;
        logic [5:0] optional_length;
        logic       last;
    } frame_word_t;

    frame_word_t expected_words[$];

    logic [7:0]  buf_bytes[64];
    int          buf_fill;
    int          idle_count;
    logic [15:0] gap_limit;

    function automatic logic [7:0] crc_over(int from, int upto);
        logic [7:0] c;
        c = 8'h00;
        for (int i = from; i < upto && i < 64; i++)
        begin
            c = c ^ buf_bytes[i];
            for (int b = 0; b < 8; b++)
            begin
                c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    task automatic drop_bytes(int n);
        if (n >= buf_fill)
        begin
            buf_fill = 0;
        end
        else
        begin
            for (int i = 0; i < buf_fill - n; i++)
            begin
                buf_bytes[i] = buf_bytes[i + n];
            end
            buf_fill -= n;
        end
    endtask

    task automatic hunt_next_sync();
        int found;
        found = 0;
        for (int i = 1; i < buf_fill; i++)
        begin
            if (found == 0 && buf_bytes[i] == SYNC_VALUE)
            begin
                found = i;
            end
        end
        if (found != 0)
        begin
            drop_bytes(found);
        end
        else
        begin
            buf_fill = 0;
        end
    endtask

    task automatic search_frame(output int frame_len);
        int lead;
        int total;
        frame_len = 0;
        forever
        begin
            lead = 0;
            while (lead < buf_fill && buf_bytes[lead] != SYNC_VALUE)
            begin
                lead++;
            end
            drop_bytes(lead);
            if (buf_fill < HEADER_BYTES)
            begin
                return;
            end
            total = HEADER_BYTES + ((int'(buf_bytes[1]) << 8) | int'(buf_bytes[2]))
                    + int'(buf_bytes[3]) + 1;
            if (total > 64)
            begin
                hunt_next_sync();
                continue;
            end
            if (buf_fill < total)
            begin
                return;
            end
            if (crc_over(1, 5) != buf_bytes[5]
                || crc_over(HEADER_BYTES, total - 1) != buf_bytes[total - 1])
            begin
                hunt_next_sync();
                continue;
            end
            frame_len = total;
            return;
        end
    endtask

    task automatic take_input(logic [1:0] mode, logic [7:0] rx);
        int total;
        frame_word_t w;
        if (mode == MODE_TICK)
        begin
            if (idle_count < 65535)
            begin
                idle_count++;
            end
        end
        else if (mode == MODE_FLUSH)
        begin
            buf_fill = 0;
        end
        else if (mode == MODE_BYTE)
        begin
            if (buf_fill != 0 && idle_count > int'(gap_limit))
            begin
                buf_fill = 0;
            end
            idle_count = 0;
            if (buf_fill >= 64)
            begin
                buf_fill = 0;
            end
            buf_bytes[buf_fill] = rx;
            buf_fill++;
            search_frame(total);
            for (int i = 0; i < total; i++)
            begin
                w.packet_byte     = buf_bytes[i];
                w.byte_index      = 6'(i);
                w.data_length     = buf_bytes[2][5:0];
                w.optional_length = buf_bytes[3][5:0];
                w.last            = (i + 1 == total);
                expected_words.insert(expected_words.size(), w);
            end
            drop_bytes(total);
        end
    endtask

    assign pending_words = expected_words.size();

    always @(posedge clk or negedge rst_n)
    begin
        frame_word_t exp_w;
        int errs;
        if (!rst_n)
        begin
            buf_fill   = 0;
            idle_count = 0;
            gap_limit  = GAP_TIMEOUT_RESET;
            fail_count <= 0;
            expected_words.delete();
        end
        else
        begin
            errs = 0;
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                gap_limit = cfg_mon.data;
            end
            if (in_mon.valid && in_mon.ready)
            begin
                take_input(in_mon.mode, in_mon.rx_byte);
            end
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word: packet_byte %0h", out_mon.packet_byte);
                    errs++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (out_mon.packet_byte !== exp_w.packet_byte)
                    begin
                        $error("packet_byte expected %0h actual %0h",
                               exp_w.packet_byte, out_mon.packet_byte);
                        errs++;
                    end
                    if (out_mon.byte_index !== exp_w.byte_index)
                    begin
                        $error("byte_index expected %0d actual %0d",
                               exp_w.byte_index, out_mon.byte_index);
                        errs++;
                    end
                    if (out_mon.data_length !== exp_w.data_length)
                    begin
                        $error("data_length expected %0d actual %0d",
                               exp_w.data_length, out_mon.data_length);
                        errs++;
                    end
                    if (out_mon.optional_length !== exp_w.optional_length)
                    begin
                        $error("optional_length expected %0d actual %0d",
                               exp_w.optional_length, out_mon.optional_length);
                        errs++;
                    end
                    if (out_mon.last !== exp_w.last)
                    begin
                        $error("last expected %0b actual %0b", exp_w.last, out_mon.last);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives received bytes, ticks and flushes into the deframer, changes the
// gap timeout between phases and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
    import esp3_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_words;
    int   cycle_count = 0;
    logic no_idling;

    esp3_in_if  in_ch();
    esp3_out_if out_ch();
    esp3_cfg_if cfg_ch();

    esp3_packet_deframer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    esp3_deframer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_mon        (in_ch),
        .out_mon       (out_ch),
        .cfg_mon       (cfg_ch),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // The watchdog: a run that stalls forever is a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // The receiver stalls now and then in random bursts, except in the final part.
    always @(negedge clk)
    begin
        if (!no_idling && $urandom_range(0, 5) == 0)
        begin
            out_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        out_ch.ready <= 1'b1;
    end

    // Sends one word. The sender may idle first; valid is held high
    // across back to back words and dropped by drain().
    task automatic send_word(logic [1:0] mode, logic [7:0] rx);
        if (!no_idling && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= mode;
        in_ch.rx_byte <= rx;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Waits until every expected word has come out and the engine has
    // had time to finish any search that produces nothing.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_words != 0)
        begin
            @(negedge clk);
        end
        repeat (400) @(negedge clk);
    endtask

    task automatic write_gap_limit(logic [15:0] value);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Sends a complete frame; corrupt selects which part is broken.
    task automatic send_frame(int dlen, int olen, int corrupt);
        logic [7:0] hdr[6];
        logic [7:0] body[64];
        logic [7:0] c;
        hdr[0] = SYNC_VALUE;
        hdr[1] = 8'h00;
        hdr[2] = 8'(dlen);
        hdr[3] = 8'(olen);
        hdr[4] = 8'($urandom_range(0, 255));
        c = 8'h00;
        for (int i = 1; i < 5; i++)
        begin
            c = crc8_byte(c, hdr[i]);
        end
        hdr[5] = (corrupt == 1) ? ~c : c;
        c = 8'h00;
        for (int i = 0; i < dlen + olen; i++)
        begin
            body[i] = 8'($urandom_range(0, 255));
            c = crc8_byte(c, body[i]);
        end
        for (int i = 0; i < 6; i++)
        begin
            send_word(MODE_BYTE, hdr[i]);
        end
        for (int i = 0; i < dlen + olen; i++)
        begin
            send_word(MODE_BYTE, body[i]);
        end
        send_word(MODE_BYTE, (corrupt == 2) ? ~c : c);
    endtask

    task automatic random_phase(int count, int max_len);
        int pick;
        int dlen;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 19);
            dlen = $urandom_range(0, max_len);
            if (pick < 12)
            begin
                send_frame(dlen, $urandom_range(0, max_len - dlen), 0);
            end
            else if (pick < 14)
            begin
                send_frame(dlen, $urandom_range(0, max_len - dlen), $urandom_range(1, 2));
            end
            else if (pick < 16)
            begin
                send_word(MODE_BYTE, 8'($urandom_range(0, 255)));
            end
            else if (pick < 18)
            begin
                repeat ($urandom_range(1, 6)) send_word(MODE_TICK, 8'($urandom_range(0, 255)));
            end
            else if (pick == 18)
            begin
                send_word(MODE_FLUSH, 8'($urandom_range(0, 255)));
            end
            else
            begin
                send_word(2'd3, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        no_idling    = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.mode   = MODE_TICK;
        in_ch.rx_byte = 8'h00;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = 16'h0000;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: a minimal frame, the largest frame, both CRC
        // faults, leading junk, an oversize header, flush and mode 3.
        send_frame(0, 0, 0);
        send_word(MODE_BYTE, 8'hFF);
        send_word(MODE_BYTE, 8'h00);
        send_frame(57, 0, 0);
        send_frame(0, 57, 0);
        send_frame(2, 1, 1);
        send_frame(2, 1, 2);
        send_word(MODE_BYTE, SYNC_VALUE);
        send_word(MODE_BYTE, 8'hFF);
        send_word(MODE_BYTE, 8'hFF);
        send_word(MODE_BYTE, 8'hFF);
        send_word(MODE_BYTE, 8'hAA);
        send_word(MODE_BYTE, 8'h00);
        send_word(MODE_FLUSH, 8'hAA);
        send_word(2'd3, 8'h55);
        send_frame(1, 1, 0);

        // Gap timeout of zero: a tick inside a frame breaks it.
        write_gap_limit(16'h0000);
        send_word(MODE_BYTE, SYNC_VALUE);
        send_word(MODE_TICK, 8'h00);
        send_word(MODE_BYTE, 8'h00);
        random_phase(6, 8);

        write_gap_limit(16'hFFFF);
        random_phase(6, 12);

        write_gap_limit(16'd3);
        random_phase(8, 6);

        write_gap_limit(16'h5AA5);
        random_phase(6, 10);

        // Final part runs without idling on either side.
        no_idling = 1'b1;
        random_phase(4, 8);
        drain();

        if (fail_count == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/esp3_pkg.sv
rtl/esp3_if.sv
rtl/esp3_packet_deframer.sv
test/esp3_deframer_checker.sv
test/tb.sv
